// ----- design/ootc_pkg.sv -----
`timescale 1ns / 1ps
package ootc_pkg;

  localparam int MAX_PENDING = 64;
  localparam int ADDR_W      = $clog2(MAX_PENDING);
  localparam int CNT_W       = $clog2(MAX_PENDING + 1);
  localparam int OFF_W       = 48;
  localparam int LEN_W       = 32;
  localparam int RIDX_W      = 9;
  localparam int RCNT_W      = 10;
  localparam int SHIFT_W     = 4;
  localparam int KEY_W       = OFF_W + RCNT_W;
  localparam int PCNT_W      = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 48;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_RATCHET_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET  = 2'd1;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [OFF_W-1:0] off;
    logic [LEN_W-1:0] len;
  } ootc_slot_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_CHK,
    ST_INS_CMP,
    ST_DRAIN_RD,
    ST_DRAIN_CMP,
    ST_REM_LD,
    ST_REM_CUR,
    ST_SD_CHK,
    ST_SD_L,
    ST_SD_R,
    ST_SD_CMP,
    ST_OUT
  } ootc_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_INS_CHK,
    OP_INS_CMP,
    OP_DRAIN_RD,
    OP_DRAIN_CMP,
    OP_REM_LD,
    OP_REM_CUR,
    OP_SD_CHK,
    OP_SD_L,
    OP_SD_R,
    OP_SD_CMP,
    OP_OUT_LOAD
  } ootc_op_t;

  typedef struct packed {
    ootc_op_t op;
  } ootc_cmd_t;

  typedef struct packed {
    logic acc_flush;
    logic acc_direct;
    logic ins_root;
    logic ins_less;
    logic size_zero;
    logic root_match;
    logic sd_leaf;
    logic has_right;
    logic sd_less;
    logic out_busy;
  } ootc_stat_t;

  // Number of significant bits of the ratchet count
  function automatic logic [SHIFT_W-1:0] bit_len(input logic [RCNT_W-1:0] v);
    logic [SHIFT_W-1:0] n;
    n = '0;
    for (int i = 0; i < RCNT_W; i++) begin
      if (v[i]) n = SHIFT_W'(i + 1);
    end
    return n;
  endfunction

endpackage

// ----- design/ootc_ctrl.sv -----
`timescale 1ns / 1ps
module ootc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ootc_pkg::ootc_stat_t stat,
  output ootc_pkg::ootc_cmd_t  cmd
);

  ootc_pkg::ootc_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ootc_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ootc_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (stat.acc_flush)       state_nxt = ootc_pkg::ST_DRAIN_RD;
          else if (stat.acc_direct) state_nxt = ootc_pkg::ST_OUT;
          else                      state_nxt = ootc_pkg::ST_INS_CHK;
        end
      end
      ootc_pkg::ST_INS_CHK:
        state_nxt = stat.ins_root ? ootc_pkg::ST_DRAIN_RD : ootc_pkg::ST_INS_CMP;
      ootc_pkg::ST_INS_CMP:
        state_nxt = stat.ins_less ? ootc_pkg::ST_INS_CHK : ootc_pkg::ST_DRAIN_RD;
      ootc_pkg::ST_DRAIN_RD:
        state_nxt = stat.size_zero ? ootc_pkg::ST_OUT : ootc_pkg::ST_DRAIN_CMP;
      ootc_pkg::ST_DRAIN_CMP:
        state_nxt = stat.root_match ? ootc_pkg::ST_REM_LD : ootc_pkg::ST_OUT;
      ootc_pkg::ST_REM_LD:
        state_nxt = stat.size_zero ? ootc_pkg::ST_DRAIN_RD : ootc_pkg::ST_REM_CUR;
      ootc_pkg::ST_REM_CUR:
        state_nxt = ootc_pkg::ST_SD_CHK;
      ootc_pkg::ST_SD_CHK:
        state_nxt = stat.sd_leaf ? ootc_pkg::ST_DRAIN_RD : ootc_pkg::ST_SD_L;
      ootc_pkg::ST_SD_L:
        state_nxt = stat.has_right ? ootc_pkg::ST_SD_R : ootc_pkg::ST_SD_CMP;
      ootc_pkg::ST_SD_R:
        state_nxt = ootc_pkg::ST_SD_CMP;
      ootc_pkg::ST_SD_CMP:
        state_nxt = stat.sd_less ? ootc_pkg::ST_SD_CHK : ootc_pkg::ST_DRAIN_RD;
      ootc_pkg::ST_OUT:
        if (!stat.out_busy) state_nxt = ootc_pkg::ST_IDLE;
      default: state_nxt = ootc_pkg::ST_IDLE;
    endcase
  end

  // Command decode
  always_comb begin
    cmd.op   = ootc_pkg::OP_NONE;
    in_stall = 1'b1;
    case (state_r)
      ootc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) cmd.op = ootc_pkg::OP_ACCEPT;
      end
      ootc_pkg::ST_INS_CHK:   cmd.op = ootc_pkg::OP_INS_CHK;
      ootc_pkg::ST_INS_CMP:   cmd.op = ootc_pkg::OP_INS_CMP;
      ootc_pkg::ST_DRAIN_RD:  cmd.op = ootc_pkg::OP_DRAIN_RD;
      ootc_pkg::ST_DRAIN_CMP: cmd.op = ootc_pkg::OP_DRAIN_CMP;
      ootc_pkg::ST_REM_LD:    cmd.op = ootc_pkg::OP_REM_LD;
      ootc_pkg::ST_REM_CUR:   cmd.op = ootc_pkg::OP_REM_CUR;
      ootc_pkg::ST_SD_CHK:    cmd.op = ootc_pkg::OP_SD_CHK;
      ootc_pkg::ST_SD_L:      cmd.op = ootc_pkg::OP_SD_L;
      ootc_pkg::ST_SD_R:      cmd.op = ootc_pkg::OP_SD_R;
      ootc_pkg::ST_SD_CMP:    cmd.op = ootc_pkg::OP_SD_CMP;
      ootc_pkg::ST_OUT:
        if (!stat.out_busy) cmd.op = ootc_pkg::OP_OUT_LOAD;
      default: cmd.op = ootc_pkg::OP_NONE;
    endcase
  end

endmodule

// ----- design/ootc_dp.sv -----
`timescale 1ns / 1ps
module ootc_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ootc_pkg::ootc_cmd_t                 cmd,
  output ootc_pkg::ootc_stat_t                stat,
  input  logic                                in_is_flush,
  input  logic [ootc_pkg::OFF_W-1:0]          in_entry_offset,
  input  logic [ootc_pkg::LEN_W-1:0]          in_entry_length,
  input  logic [ootc_pkg::RIDX_W-1:0]         in_ratchet_index,
  input  logic                                cfg_we,
  input  logic [ootc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ootc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_status,
  output logic [ootc_pkg::OFF_W-1:0]          out_next_offset,
  output logic [ootc_pkg::PCNT_W-1:0]         out_pending_count,
  output logic                                out_tail_clean
);

  localparam int AW = ootc_pkg::ADDR_W;

  ootc_pkg::ootc_slot_t mem [ootc_pkg::MAX_PENDING];
  ootc_pkg::ootc_slot_t rdata_r, cur_r, cur_nxt, chd_r, chd_nxt, wdata;
  logic [AW-1:0]                 pos_r, pos_nxt, chd_idx_r, chd_idx_nxt;
  logic [AW-1:0]                 raddr, waddr, parent;
  logic                          re, we;
  logic [ootc_pkg::OFF_W-1:0]    exp_r, exp_nxt;
  logic [ootc_pkg::CNT_W-1:0]    size_r, size_nxt;
  logic [ootc_pkg::SHIFT_W-1:0]  shift_r;
  logic                          res_full_r, res_full_nxt;
  logic [AW+1:0]                 l_ext, r_ext, size_ext;
  logic [ootc_pkg::KEY_W-1:0]    new_key;
  logic                          full, off_match;

  // Tree navigation
  assign parent   = AW'((pos_r - AW'(1)) >> 1);
  assign l_ext    = (AW+2)'({pos_r, 1'b1});
  assign r_ext    = l_ext + (AW+2)'(1);
  assign size_ext = (AW+2)'(size_r);

  assign full      = (size_r == ootc_pkg::CNT_W'(ootc_pkg::MAX_PENDING));
  assign off_match = (in_entry_offset == exp_r);
  assign new_key   = (ootc_pkg::KEY_W'(in_entry_offset) << shift_r)
                   + ootc_pkg::KEY_W'(in_ratchet_index);

  // Status to the controller
  always_comb begin
    stat.acc_flush  = in_is_flush;
    stat.acc_direct = !in_is_flush && (off_match || full);
    stat.ins_root   = (pos_r == '0);
    stat.ins_less   = (cur_r.key < rdata_r.key);
    stat.size_zero  = (size_r == '0);
    stat.root_match = (rdata_r.off == exp_r);
    stat.sd_leaf    = (l_ext >= size_ext);
    stat.has_right  = (r_ext < size_ext);
    stat.sd_less    = (chd_r.key < cur_r.key);
    stat.out_busy   = out_valid && out_stall;
  end

  // Per-operation datapath actions
  always_comb begin
    exp_nxt      = exp_r;
    size_nxt     = size_r;
    cur_nxt      = cur_r;
    chd_nxt      = chd_r;
    pos_nxt      = pos_r;
    chd_idx_nxt  = chd_idx_r;
    res_full_nxt = res_full_r;
    re           = 1'b0;
    raddr        = '0;
    we           = 1'b0;
    waddr        = pos_r;
    wdata        = cur_r;
    case (cmd.op)
      ootc_pkg::OP_ACCEPT: begin
        res_full_nxt = !in_is_flush && !off_match && full;
        if (!in_is_flush) begin
          if (off_match) begin
            exp_nxt = exp_r + ootc_pkg::OFF_W'(in_entry_length);
          end else if (!full) begin
            cur_nxt  = '{key: new_key, off: in_entry_offset, len: in_entry_length};
            pos_nxt  = AW'(size_r);
            size_nxt = size_r + ootc_pkg::CNT_W'(1);
          end
        end
      end
      ootc_pkg::OP_INS_CHK: begin
        if (pos_r == '0) begin
          we = 1'b1;
        end else begin
          re    = 1'b1;
          raddr = parent;
        end
      end
      ootc_pkg::OP_INS_CMP: begin
        we = 1'b1;
        if (cur_r.key < rdata_r.key) begin
          wdata   = rdata_r;
          pos_nxt = parent;
        end
      end
      ootc_pkg::OP_DRAIN_RD: begin
        re    = 1'b1;
        raddr = '0;
      end
      ootc_pkg::OP_DRAIN_CMP: begin
        if (rdata_r.off == exp_r) begin
          exp_nxt  = exp_r + ootc_pkg::OFF_W'(rdata_r.len);
          size_nxt = size_r - ootc_pkg::CNT_W'(1);
        end
      end
      ootc_pkg::OP_REM_LD: begin
        re    = 1'b1;
        raddr = AW'(size_r);
      end
      ootc_pkg::OP_REM_CUR: begin
        cur_nxt = rdata_r;
        pos_nxt = '0;
      end
      ootc_pkg::OP_SD_CHK: begin
        if (l_ext >= size_ext) begin
          we = 1'b1;
        end else begin
          re    = 1'b1;
          raddr = AW'(l_ext);
        end
      end
      ootc_pkg::OP_SD_L: begin
        chd_nxt     = rdata_r;
        chd_idx_nxt = AW'(l_ext);
        if (r_ext < size_ext) begin
          re    = 1'b1;
          raddr = AW'(r_ext);
        end
      end
      ootc_pkg::OP_SD_R: begin
        if (rdata_r.key < chd_r.key) begin
          chd_nxt     = rdata_r;
          chd_idx_nxt = AW'(r_ext);
        end
      end
      ootc_pkg::OP_SD_CMP: begin
        we = 1'b1;
        if (chd_r.key < cur_r.key) begin
          wdata   = chd_r;
          pos_nxt = chd_idx_r;
        end
      end
      default: ;
    endcase
  end

  // Pending store
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  // Working registers
  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    chd_r      <= chd_nxt;
    pos_r      <= pos_nxt;
    chd_idx_r  <= chd_idx_nxt;
    res_full_r <= res_full_nxt;
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r   <= '0;
      size_r  <= '0;
      shift_r <= ootc_pkg::bit_len(ootc_pkg::RCNT_W'(1));
    end else begin
      size_r <= size_nxt;
      if (cfg_we && cfg_index == ootc_pkg::REG_RATCHET_COUNT)
        shift_r <= ootc_pkg::bit_len(cfg_wdata[ootc_pkg::RCNT_W-1:0]);
      if (cfg_we && cfg_index == ootc_pkg::REG_START_OFFSET)
        exp_r <= cfg_wdata[ootc_pkg::OFF_W-1:0];
      else
        exp_r <= exp_nxt;
    end
  end

  // Output register: hold until transferred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.op == ootc_pkg::OP_OUT_LOAD) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == ootc_pkg::OP_OUT_LOAD) begin
      out_status        <= res_full_r;
      out_next_offset   <= exp_r;
      out_pending_count <= ootc_pkg::PCNT_W'(size_r);
      out_tail_clean    <= (size_r == '0);
    end
  end

endmodule

// ----- design/out_of_order_coverage_tracker_core.sv -----
`timescale 1ns / 1ps
// A direct or dropped record goes straight to the result register; an insert first sifts
// the record up the heap to its place, then an insert or a flush checks the heap root and
// drains each record that matches the expected offset, moving the last record to the root
// and sifting it down for each drained record, until the root no longer matches.
// A new item waits for the last: the input stalls outside the idle state.
// Reset (rst_n low, synchronous) empties the store, zeroes the offset, ratchet count 1.
module out_of_order_coverage_tracker_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_is_flush,
  input  logic [ootc_pkg::OFF_W-1:0]          in_entry_offset,
  input  logic [ootc_pkg::LEN_W-1:0]          in_entry_length,
  input  logic [ootc_pkg::RIDX_W-1:0]         in_ratchet_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_status,
  output logic [ootc_pkg::OFF_W-1:0]          out_next_offset,
  output logic [ootc_pkg::PCNT_W-1:0]         out_pending_count,
  output logic                                out_tail_clean,
  input  logic                                cfg_we,
  input  logic [ootc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ootc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  ootc_pkg::ootc_cmd_t  cmd;
  ootc_pkg::ootc_stat_t stat;

  ootc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ootc_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_is_flush       (in_is_flush),
    .in_entry_offset   (in_entry_offset),
    .in_entry_length   (in_entry_length),
    .in_ratchet_index  (in_ratchet_index),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_next_offset   (out_next_offset),
    .out_pending_count (out_pending_count),
    .out_tail_clean    (out_tail_clean)
  );

endmodule

// ----- design/ootc_checker.sv -----
`timescale 1ns / 1ps
module ootc_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic                                out_status,
  input logic [ootc_pkg::OFF_W-1:0]          out_next_offset,
  input logic [ootc_pkg::PCNT_W-1:0]         out_pending_count,
  input logic                                out_tail_clean
);

  // One item at a time: stall the input after each transfer
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while an item is in flight");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_next_offset)
      && $stable(out_pending_count) && $stable(out_status))
    else $error("stalled result changed");

  // Clean tail agrees with the count
  a_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_tail_clean == (out_pending_count == '0)))
    else $error("tail_clean disagrees with pending_count");

  // A dropped record only with a full store
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |->
      out_pending_count == ootc_pkg::PCNT_W'(ootc_pkg::MAX_PENDING))
    else $error("drop reported with room in store");

  // Count never exceeds the store depth
  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pending_count <= ootc_pkg::PCNT_W'(ootc_pkg::MAX_PENDING))
    else $error("pending_count beyond store depth");

endmodule

bind out_of_order_coverage_tracker_core ootc_checker u_ootc_checker (.*);
